>>> hw/rtl/jrd_pkg.sv
// Shared constants, codes and types of the joystick radial deadzone block.
package jrd_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_RAW_MIN = 2'd0;
    localparam logic [1:0] CFG_RAW_MAX = 2'd1;
    localparam logic [1:0] CFG_INNER   = 2'd2;
    localparam logic [1:0] CFG_OUTER   = 2'd3;

    // Register values after reset.
    localparam logic signed [15:0] RST_RAW_MIN = -16'sd32768;
    localparam logic signed [15:0] RST_RAW_MAX = 16'sd32767;
    localparam logic [14:0]        RST_INNER   = 15'd7864;
    localparam logic [14:0]        RST_OUTER   = 15'd3277;

    // Zone codes.
    localparam logic [1:0] ZONE_INNER = 2'd0;
    localparam logic [1:0] ZONE_LIVE  = 2'd1;
    localparam logic [1:0] ZONE_SNAP  = 2'd2;

    // Quotient width of the dividers (Q0.15 magnitude).
    localparam int QW = 15;

    // Arctangent table in 1/(64*4096) degree.
    localparam int ATAN_LEN = 24;
    localparam logic [23:0] ATAN_TABLE [ATAN_LEN] = '{
        24'd11796480, 24'd6963869, 24'd3679517, 24'd1867780, 24'd937515, 24'd469214,
        24'd234664, 24'd117339, 24'd58671, 24'd29335, 24'd14668, 24'd7334,
        24'd3667, 24'd1833, 24'd917, 24'd458, 24'd229, 24'd115,
        24'd57, 24'd29, 24'd14, 24'd7, 24'd4, 24'd2
    };
    localparam int ZW = 28;
    localparam logic signed [ZW-1:0] Z_180 = 28'sd47185920;
    localparam logic [16:0] ANGLE_LIMIT = 17'd11520;

    // Side data that travels with the normalizing divisions.
    typedef struct packed {
        logic neg_x;
        logic neg_y;
        logic dz;
    } t_norm_side;

    // Normalized position.
    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
    } t_xy;

    // Side data that travels with the snap divisions.
    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [15:0]        mag;
        logic [1:0]         zone;
    } t_snap_side;

    // Result fields ahead of the angle.
    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [14:0]        magnitude;
        logic [1:0]         zone;
    } t_res;

endpackage

>>> hw/rtl/jrd_in_if.sv
// Request channel carrying one raw stick sample.
interface jrd_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] raw_x;
    logic signed [15:0] raw_y;

    modport source (output valid, output raw_x, output raw_y, input ready);
    modport sink (input valid, input raw_x, input raw_y, output ready);
endinterface

>>> hw/rtl/jrd_out_if.sv
// Result channel carrying one corrected stick position.
interface jrd_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [14:0]        magnitude;
    logic signed [14:0] angle;
    logic [1:0]         zone;

    modport source (output valid, output pos_x, output pos_y, output magnitude,
                    output angle, output zone, input ready);
    modport sink (input valid, input pos_x, input pos_y, input magnitude,
                  input angle, input zone, output ready);
endinterface

>>> hw/rtl/jrd_div.sv
// Pipelined restoring divider, one quotient bit per stage, saturating quotient.
module jrd_div #(
    parameter int NW = 34,
    parameter int DW = 16,
    parameter int QW = 15
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [QW-1:0] o_quo
);
    localparam int RW = (NW > DW + QW) ? NW : DW + QW;

    logic [RW-1:0] r_rem [QW+1];
    logic [DW-1:0] r_den [QW+1];
    logic [QW-1:0] r_quo [QW+1];
    logic          r_sat [QW+1];

    // Entry stage flags quotients that do not fit in QW bits.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= RW'(i_num);
            r_den[0] <= i_den;
            r_quo[0] <= '0;
            r_sat[0] <= RW'(i_num) >= (RW'(i_den) << QW);
        end
    end

    // One trial subtraction per stage, most significant quotient bit first.
    for (genvar j = 0; j < QW; j++) begin : g_stage
        localparam int K = QW - 1 - j;
        logic [RW-1:0] w_trial;
        logic          w_ge;
        assign w_trial = RW'(r_den[j]) << K;
        assign w_ge    = r_rem[j] >= w_trial;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j+1] <= w_ge ? r_rem[j] - w_trial : r_rem[j];
                r_den[j+1] <= r_den[j];
                r_quo[j+1] <= r_quo[j] | (QW'(w_ge) << K);
                r_sat[j+1] <= r_sat[j];
            end
        end
    end

    assign o_quo = r_sat[QW] ? '1 : r_quo[QW];

endmodule

>>> hw/rtl/joystick_radial_deadzone.sv
// Top level of the joystick radial deadzone block.
//
// Usage: a raw two-axis sample enters on the i_in request channel
// (valid/ready) and one corrected result leaves on o_out for every sample:
// position, magnitude (Q0.15), angle in 1/64 degree and zone code.
// Configuration registers are written through i_cfg_we/i_cfg_idx/i_cfg_data
// while no request is in flight; writes take effect at once.
// The pipeline depth from acceptance to the result showing on o_out is set
// by the two chains of bit-per-stage dividers, the bit-per-stage square root
// and the CORDIC stages. One request is accepted every cycle while the
// receiver is not stalling a finished result.
// When the receiver stalls with a result waiting, the whole pipeline holds;
// i_in.ready follows o_out.ready in that case and no request is lost.
// Reset clears all valid bits and loads the register defaults; payload
// registers are left as they are.
module joystick_radial_deadzone #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    jrd_in_if.sink      i_in,
    jrd_out_if.source   o_out
);
    localparam int NS   = (CORDIC_STEPS > jrd_pkg::ATAN_LEN) ? jrd_pkg::ATAN_LEN
                                                              : CORDIC_STEPS;
    localparam int DLAT = jrd_pkg::QW + 1;
    localparam int SQN  = 16;
    localparam int L    = 9 + 2 * DLAT + SQN + NS;
    localparam int CW   = 26;
    localparam int ZW   = jrd_pkg::ZW;

    // Configuration registers.
    logic signed [15:0] r_raw_min;
    logic signed [15:0] r_raw_max;
    logic [14:0]        r_inner;
    logic [14:0]        r_outer;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw_min <= jrd_pkg::RST_RAW_MIN;
            r_raw_max <= jrd_pkg::RST_RAW_MAX;
            r_inner   <= jrd_pkg::RST_INNER;
            r_outer   <= jrd_pkg::RST_OUTER;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                jrd_pkg::CFG_RAW_MIN: r_raw_min <= i_cfg_data;
                jrd_pkg::CFG_RAW_MAX: r_raw_max <= i_cfg_data;
                jrd_pkg::CFG_INNER:   r_inner   <= i_cfg_data[14:0];
                jrd_pkg::CFG_OUTER:   r_outer   <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // Pipeline advance: every stage moves unless a finished result is stuck.
    logic         w_en;
    logic [L-1:0] r_vld;

    assign w_en       = !r_vld[L-1] || o_out.ready;
    assign i_in.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[L-2:0], i_in.valid};
        end
    end

    // Stage A: numerators of the axis normalization and the raw span.
    logic signed [16:0] w_span;
    logic signed [18:0] w_nx;
    logic signed [18:0] w_ny;
    logic signed [18:0] r_a_nx;
    logic signed [18:0] r_a_ny;
    logic signed [16:0] r_a_d;

    assign w_span = 17'($signed(r_raw_max)) - 17'($signed(r_raw_min));
    assign w_nx = ((19'($signed(i_in.raw_x)) - 19'($signed(r_raw_min))) <<< 1)
                - 19'($signed(w_span));
    assign w_ny = ((19'($signed(i_in.raw_y)) - 19'($signed(r_raw_min))) <<< 1)
                - 19'($signed(w_span));

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_nx <= w_nx;
            r_a_ny <= w_ny;
            r_a_d  <= w_span;
        end
    end

    // Normalizing divisions: |n| * 32768 + |d| / 2 over |d|.
    logic [18:0]              w_abs_nx;
    logic [18:0]              w_abs_ny;
    logic [16:0]              w_abs_d;
    logic [33:0]              w_num_x;
    logic [33:0]              w_num_y;
    logic [jrd_pkg::QW-1:0]   w_qx;
    logic [jrd_pkg::QW-1:0]   w_qy;
    jrd_pkg::t_norm_side      r_ns [DLAT];

    assign w_abs_nx = r_a_nx[18] ? 19'(-r_a_nx) : 19'(r_a_nx);
    assign w_abs_ny = r_a_ny[18] ? 19'(-r_a_ny) : 19'(r_a_ny);
    assign w_abs_d  = r_a_d[16] ? 17'(-r_a_d) : 17'(r_a_d);
    assign w_num_x  = 34'({w_abs_nx[17:0], 15'd0}) + 34'(w_abs_d[15:1]);
    assign w_num_y  = 34'({w_abs_ny[17:0], 15'd0}) + 34'(w_abs_d[15:1]);

    jrd_div #(.NW(34), .DW(16), .QW(jrd_pkg::QW)) u_div_nx (
        .i_clk (i_clk), .i_en (w_en), .i_num (w_num_x), .i_den (w_abs_d[15:0]),
        .o_quo (w_qx)
    );
    jrd_div #(.NW(34), .DW(16), .QW(jrd_pkg::QW)) u_div_ny (
        .i_clk (i_clk), .i_en (w_en), .i_num (w_num_y), .i_den (w_abs_d[15:0]),
        .o_quo (w_qy)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ns[0].neg_x <= r_a_nx[18] ^ r_a_d[16];
            r_ns[0].neg_y <= r_a_ny[18] ^ r_a_d[16];
            r_ns[0].dz    <= (r_a_d == '0);
            for (int k = 1; k < DLAT; k++) begin
                r_ns[k] <= r_ns[k-1];
            end
        end
    end

    // Stage C: signed normalized axes; an empty raw span gives zero.
    jrd_pkg::t_xy r_c;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r_ns[DLAT-1].dz) begin
                r_c.x <= '0;
                r_c.y <= '0;
            end else begin
                r_c.x <= r_ns[DLAT-1].neg_x ? -16'($signed({1'b0, w_qx}))
                                            : 16'($signed({1'b0, w_qx}));
                r_c.y <= r_ns[DLAT-1].neg_y ? -16'($signed({1'b0, w_qy}))
                                            : 16'($signed({1'b0, w_qy}));
            end
        end
    end

    // Stage D: squares of both axes.
    logic signed [31:0] w_xx;
    logic signed [31:0] w_yy;
    logic [29:0]        r_d_xx;
    logic [29:0]        r_d_yy;
    jrd_pkg::t_xy       r_d;

    assign w_xx = r_c.x * r_c.x;
    assign w_yy = r_c.y * r_c.y;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d_xx <= w_xx[29:0];
            r_d_yy <= w_yy[29:0];
            r_d    <= r_c;
        end
    end

    // Stage E and square root stages: one root bit per stage.
    logic [31:0]  r_sq_rem  [SQN+1];
    logic [15:0]  r_sq_root [SQN+1];
    jrd_pkg::t_xy r_sq_xy   [SQN+1];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sq_rem[0]  <= 32'(r_d_xx) + 32'(r_d_yy);
            r_sq_root[0] <= '0;
            r_sq_xy[0]   <= r_d;
        end
    end

    for (genvar j = 0; j < SQN; j++) begin : g_sqrt
        localparam int K = SQN - 1 - j;
        logic [31:0] w_trial;
        logic        w_ge;
        assign w_trial = (32'(r_sq_root[j]) << (K + 1)) + (32'd1 << (2 * K));
        assign w_ge    = r_sq_rem[j] >= w_trial;
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_sq_rem[j+1]  <= w_ge ? r_sq_rem[j] - w_trial : r_sq_rem[j];
                r_sq_root[j+1] <= r_sq_root[j] | (16'(w_ge) << K);
                r_sq_xy[j+1]   <= r_sq_xy[j];
            end
        end
    end

    // Stage F: round the root to nearest using the final remainder.
    logic [15:0]  r_f_mag;
    jrd_pkg::t_xy r_f;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f_mag <= r_sq_root[SQN]
                     + 16'(r_sq_rem[SQN] > 32'(r_sq_root[SQN]));
            r_f     <= r_sq_xy[SQN];
        end
    end

    // Stage G: zone decision and numerators of the snap divisions.
    logic [15:0]         w_abs_fx;
    logic [15:0]         w_abs_fy;
    logic [16:0]         w_snap_thr;
    logic [1:0]          w_zone;
    logic [30:0]         r_g_num_x;
    logic [30:0]         r_g_num_y;
    jrd_pkg::t_snap_side r_g;

    assign w_abs_fx   = r_f.x[15] ? 16'(-r_f.x) : 16'(r_f.x);
    assign w_abs_fy   = r_f.y[15] ? 16'(-r_f.y) : 16'(r_f.y);
    assign w_snap_thr = 17'd32768 - 17'(r_outer);

    always_comb begin
        priority if (r_f_mag <= 16'(r_inner)) begin
            w_zone = jrd_pkg::ZONE_INNER;
        end else if (17'(r_f_mag) >= w_snap_thr) begin
            w_zone = jrd_pkg::ZONE_SNAP;
        end else begin
            w_zone = jrd_pkg::ZONE_LIVE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_g_num_x <= 31'({w_abs_fx[14:0], 15'd0}) - 31'(w_abs_fx)
                       + 31'(r_f_mag[15:1]);
            r_g_num_y <= 31'({w_abs_fy[14:0], 15'd0}) - 31'(w_abs_fy)
                       + 31'(r_f_mag[15:1]);
            r_g.x     <= r_f.x;
            r_g.y     <= r_f.y;
            r_g.mag   <= r_f_mag;
            r_g.zone  <= w_zone;
        end
    end

    // Snap divisions: |axis| * 32767 over the magnitude, rounded.
    logic [jrd_pkg::QW-1:0] w_sx;
    logic [jrd_pkg::QW-1:0] w_sy;
    jrd_pkg::t_snap_side    r_ss [DLAT];

    jrd_div #(.NW(31), .DW(16), .QW(jrd_pkg::QW)) u_div_sx (
        .i_clk (i_clk), .i_en (w_en), .i_num (r_g_num_x), .i_den (r_g.mag),
        .o_quo (w_sx)
    );
    jrd_div #(.NW(31), .DW(16), .QW(jrd_pkg::QW)) u_div_sy (
        .i_clk (i_clk), .i_en (w_en), .i_num (r_g_num_y), .i_den (r_g.mag),
        .o_quo (w_sy)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ss[0] <= r_g;
            for (int k = 1; k < DLAT; k++) begin
                r_ss[k] <= r_ss[k-1];
            end
        end
    end

    // Stage H: pick the position and magnitude for the zone.
    jrd_pkg::t_snap_side w_hs;
    jrd_pkg::t_res       w_hres;
    jrd_pkg::t_res       r_h;
    jrd_pkg::t_xy        r_h_xy;

    assign w_hs = r_ss[DLAT-1];

    always_comb begin
        w_hres.zone = w_hs.zone;
        unique case (w_hs.zone)
            jrd_pkg::ZONE_SNAP: begin
                w_hres.pos_x     = w_hs.x[15] ? -16'($signed({1'b0, w_sx}))
                                              : 16'($signed({1'b0, w_sx}));
                w_hres.pos_y     = w_hs.y[15] ? -16'($signed({1'b0, w_sy}))
                                              : 16'($signed({1'b0, w_sy}));
                w_hres.magnitude = 15'h7FFF;
            end
            jrd_pkg::ZONE_LIVE: begin
                w_hres.pos_x     = w_hs.x;
                w_hres.pos_y     = w_hs.y;
                w_hres.magnitude = w_hs.mag[15] ? 15'h7FFF : w_hs.mag[14:0];
            end
            default: begin
                w_hres.pos_x     = '0;
                w_hres.pos_y     = '0;
                w_hres.magnitude = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_h      <= w_hres;
            r_h_xy.x <= w_hs.x;
            r_h_xy.y <= w_hs.y;
        end
    end

    // Stage I: CORDIC start; a left half-plane vector is turned by 180 degrees.
    logic signed [CW-1:0] w_x256;
    logic signed [CW-1:0] w_y256;
    logic signed [CW-1:0] r_cx   [NS+1];
    logic signed [CW-1:0] r_cy   [NS+1];
    logic signed [ZW-1:0] r_cz   [NS+1];
    jrd_pkg::t_res        r_cres [NS+1];

    assign w_x256 = CW'($signed(r_h_xy.x)) <<< 8;
    assign w_y256 = CW'($signed(r_h_xy.y)) <<< 8;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cres[0] <= r_h;
            if (r_h_xy.x[15]) begin
                r_cx[0] <= -w_x256;
                r_cy[0] <= -w_y256;
                r_cz[0] <= r_h_xy.y[15] ? -jrd_pkg::Z_180 : jrd_pkg::Z_180;
            end else begin
                r_cx[0] <= w_x256;
                r_cy[0] <= w_y256;
                r_cz[0] <= '0;
            end
        end
    end

    // CORDIC vectoring stages, one micro-rotation each.
    for (genvar i = 0; i < NS; i++) begin : g_cordic
        localparam logic signed [ZW-1:0] ATAN = ZW'(jrd_pkg::ATAN_TABLE[i]);
        logic signed [CW-1:0] w_xs;
        logic signed [CW-1:0] w_ys;
        assign w_xs = r_cx[i] >>> i;
        assign w_ys = r_cy[i] >>> i;
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_cres[i+1] <= r_cres[i];
                if (!r_cy[i][CW-1]) begin
                    r_cx[i+1] <= r_cx[i] + w_ys;
                    r_cy[i+1] <= r_cy[i] - w_xs;
                    r_cz[i+1] <= r_cz[i] + ATAN;
                end else begin
                    r_cx[i+1] <= r_cx[i] - w_ys;
                    r_cy[i+1] <= r_cy[i] + w_xs;
                    r_cz[i+1] <= r_cz[i] - ATAN;
                end
            end
        end
    end

    // Stage J: round the angle to 1/64 degree, clamp, and hold the result.
    logic [ZW-1:0]      w_abs_z;
    logic [16:0]        w_ang_q;
    logic [16:0]        w_ang_c;
    logic signed [14:0] w_angle;
    jrd_pkg::t_res      r_j;
    logic signed [14:0] r_j_angle;

    assign w_abs_z = r_cz[NS][ZW-1] ? ZW'(-r_cz[NS]) : ZW'(r_cz[NS]);
    assign w_ang_q = 17'((w_abs_z + ZW'(2048)) >> 12);
    assign w_ang_c = (w_ang_q > jrd_pkg::ANGLE_LIMIT) ? jrd_pkg::ANGLE_LIMIT : w_ang_q;

    always_comb begin
        if (r_cres[NS].zone == jrd_pkg::ZONE_INNER) begin
            w_angle = '0;
        end else if (r_cz[NS][ZW-1]) begin
            w_angle = -15'($signed(w_ang_c[14:0]));
        end else begin
            w_angle = 15'($signed(w_ang_c[14:0]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_j       <= r_cres[NS];
            r_j_angle <= w_angle;
        end
    end

    assign o_out.valid     = r_vld[L-1];
    assign o_out.pos_x     = r_j.pos_x;
    assign o_out.pos_y     = r_j.pos_y;
    assign o_out.magnitude = r_j.magnitude;
    assign o_out.angle     = r_j_angle;
    assign o_out.zone      = r_j.zone;

endmodule

>>> verif/tb_top.sv
// Self-checking testbench of the joystick radial deadzone block.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STEPS     = 16;
    localparam int LATENCY   = 57 + STEPS;
    localparam int N_RANDOM  = 1700;

    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [14:0]        magnitude;
        logic signed [14:0] angle;
        logic [1:0]         zone;
    } t_stick;

    // Directed stimulus row; has_exp marks rows with a typed-in result.
    typedef struct {
        logic signed [15:0] rx;
        logic signed [15:0] ry;
        bit                 has_exp;
        t_stick             exp;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_idx;
    logic [15:0] cfg_data;

    jrd_in_if  in_ch();
    jrd_out_if out_ch();

    joystick_radial_deadzone #(.CORDIC_STEPS(STEPS)) u_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data),
        .i_in      (in_ch.sink),
        .o_out     (out_ch.source)
    );

    // Shadow copy of the configuration registers.
    logic signed [15:0] sh_min;
    logic signed [15:0] sh_max;
    logic [14:0]        sh_inner;
    logic [14:0]        sh_outer;

    t_stick expected_q[$];
    t_stick override_q[$];
    int     n_errors;
    int     n_results;
    int     src_idle_pct;
    int     snk_idle_pct;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("Timeout with %0d results outstanding", expected_q.size());
        $display("CHECKS FAILED");
        $finish;
    end

    // Rounded division, half away from zero.
    function automatic longint div_rnd(longint n, longint d);
        longint un;
        longint ud;
        longint q;
        un = n < 0 ? -n : n;
        ud = d < 0 ? -d : d;
        q = (un + ud / 2) / ud;
        return ((n < 0) != (d < 0)) ? -q : q;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint norm_axis(longint raw);
        longint span;
        span = longint'(sh_max) - longint'(sh_min);
        if (span == 0) return 0;
        return clip(div_rnd((2 * (raw - sh_min) - span) * 32768, span), -32767, 32767);
    endfunction

    // Integer square root, rounded to nearest.
    function automatic longint isqrt_rnd(longint s);
        longint r;
        r = longint'($sqrt(real'(s)));
        while (r * r > s) r--;
        while ((r + 1) * (r + 1) <= s) r++;
        if (s - r * r > r) r++;
        return r;
    endfunction

    // Vectoring-mode CORDIC angle in 1/64 degree.
    function automatic longint stick_angle(longint x0, longint y0);
        longint x;
        longint y;
        longint z;
        longint xn;
        x = x0 * 256;
        y = y0 * 256;
        z = 0;
        if (x < 0) begin
            z = (y >= 0) ? 64'sd47185920 : -64'sd47185920;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < STEPS && i < jrd_pkg::ATAN_LEN; i++) begin
            if (y >= 0) begin
                xn = x + (y >>> i);
                y  = y - (x >>> i);
                z += longint'(jrd_pkg::ATAN_TABLE[i]);
            end else begin
                xn = x - (y >>> i);
                y  = y + (x >>> i);
                z -= longint'(jrd_pkg::ATAN_TABLE[i]);
            end
            x = xn;
        end
        return clip(div_rnd(z, 4096), -11520, 11520);
    endfunction

    function automatic t_stick predict_stick(logic signed [15:0] rx, logic signed [15:0] ry);
        t_stick r;
        longint x;
        longint y;
        longint mag;
        x = norm_axis(rx);
        y = norm_axis(ry);
        mag = isqrt_rnd(x * x + y * y);
        r = '0;
        if (mag <= longint'(sh_inner)) begin
            r.zone = jrd_pkg::ZONE_INNER;
        end else if (mag >= 32768 - longint'(sh_outer)) begin
            r.zone = jrd_pkg::ZONE_SNAP;
            r.angle = 15'(stick_angle(x, y));
            r.magnitude = 15'd32767;
            r.pos_x = 16'(clip(div_rnd(x * 32767, mag), -32767, 32767));
            r.pos_y = 16'(clip(div_rnd(y * 32767, mag), -32767, 32767));
        end else begin
            r.zone = jrd_pkg::ZONE_LIVE;
            r.angle = 15'(stick_angle(x, y));
            r.magnitude = 15'(clip(mag, 0, 32767));
            r.pos_x = 16'(x);
            r.pos_y = 16'(y);
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("Mismatch on %s in result %0d: got %0d, expected %0d",
                 what, n_results, got, want);
        n_errors++;
    endtask

    // Register write, only while nothing is in flight.
    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        case (idx)
            jrd_pkg::CFG_RAW_MIN: sh_min   = val;
            jrd_pkg::CFG_RAW_MAX: sh_max   = val;
            jrd_pkg::CFG_INNER:   sh_inner = val[14:0];
            default:              sh_outer = val[14:0];
        endcase
    endtask

    // Drop the request line, then wait until every result has come back.
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // Offer one request, idling at random beforehand; valid stays up afterwards
    // so that the next request can follow without a gap.
    task automatic send_sample(logic signed [15:0] rx, logic signed [15:0] ry);
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.raw_x <= rx;
        in_ch.raw_y <= ry;
        expected_q.push_back(predict_stick(rx, ry));
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // Receiver: random stalls; compares with override rows, then expectations.
    always @(posedge i_clk) begin
        t_stick got;
        t_stick want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                got = '{out_ch.pos_x, out_ch.pos_y, out_ch.magnitude, out_ch.angle, out_ch.zone};
                if (expected_q.size() == 0) begin
                    $display("Result with no request outstanding");
                    n_errors++;
                end else begin
                    want = expected_q.pop_front();
                    if (override_q.size() != 0 && n_results < override_q.size())
                        want = override_q[n_results];
                    if (got.pos_x != want.pos_x) report_mismatch("pos_x", got.pos_x, want.pos_x);
                    if (got.pos_y != want.pos_y) report_mismatch("pos_y", got.pos_y, want.pos_y);
                    if (got.magnitude != want.magnitude)
                        report_mismatch("magnitude", got.magnitude, want.magnitude);
                    if (got.angle != want.angle) report_mismatch("angle", got.angle, want.angle);
                    if (got.zone != want.zone) report_mismatch("zone", got.zone, want.zone);
                end
                n_results++;
            end
            out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    initial begin
        t_row rows[$];
        t_row row;
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = jrd_pkg::CFG_RAW_MIN;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.raw_x = '0;
        in_ch.raw_y = '0;
        n_errors = 0;
        n_results = 0;
        src_idle_pct = 18;
        snk_idle_pct = 62;
        sh_min = jrd_pkg::RST_RAW_MIN;
        sh_max = jrd_pkg::RST_RAW_MAX;
        sh_inner = jrd_pkg::RST_INNER;
        sh_outer = jrd_pkg::RST_OUTER;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows under the reset configuration.
        rows.push_back('{-16'sd1, -16'sd1, 1'b1,
                         '{16'sd0, 16'sd0, 15'd0, 15'sd0, jrd_pkg::ZONE_INNER}});
        rows.push_back('{16'sd0, 16'sd0, 1'b1,
                         '{16'sd0, 16'sd0, 15'd0, 15'sd0, jrd_pkg::ZONE_INNER}});
        rows.push_back('{16'sd32767, -16'sd1, 1'b1,
                         '{16'sd32767, -16'sd1, 15'd32767, 15'sd0, jrd_pkg::ZONE_SNAP}});
        rows.push_back('{-16'sd32768, -16'sd32768, 1'b0, '0});
        rows.push_back('{16'sd32767, 16'sd32767, 1'b0, '0});
        rows.push_back('{-16'sd32768, 16'sd32767, 1'b0, '0});
        rows.push_back('{-16'sd32768, -16'sd1, 1'b0, '0});
        rows.push_back('{-16'sd32768, -16'sd2, 1'b0, '0});
        rows.push_back('{-16'sd1, 16'sd32767, 1'b0, '0});
        rows.push_back('{16'sd12000, 16'sd9000, 1'b0, '0});
        rows.push_back('{-16'sd20000, -16'sd5000, 1'b0, '0});
        rows.push_back('{16'sd3000, 16'sd3000, 1'b0, '0});
        rows.push_back('{16'sd30000, 16'sd1000, 1'b0, '0});
        foreach (rows[i]) begin
            row = rows[i];
            if (row.has_exp) override_q.push_back(row.exp);
            else override_q.push_back(predict_stick(row.rx, row.ry));
        end
        foreach (rows[i]) send_sample(rows[i].rx, rows[i].ry);
        drain();

        // Equal range, inverted range, zero widths, widest widths.
        write_reg(jrd_pkg::CFG_RAW_MIN, 16'd100);
        write_reg(jrd_pkg::CFG_RAW_MAX, 16'd100);
        send_sample(16'sd32767, -16'sd32768);
        drain();
        write_reg(jrd_pkg::CFG_RAW_MIN, 16'h7fff);
        write_reg(jrd_pkg::CFG_RAW_MAX, 16'h8000);
        write_reg(jrd_pkg::CFG_INNER, 16'd0);
        write_reg(jrd_pkg::CFG_OUTER, 16'd0);
        send_sample(16'sd32767, 16'sd32767);
        send_sample(-16'sd32768, 16'sd100);
        send_sample(16'sd0, 16'sd0);
        drain();
        write_reg(jrd_pkg::CFG_RAW_MIN, 16'hfc18);
        write_reg(jrd_pkg::CFG_RAW_MAX, 16'd1000);
        write_reg(jrd_pkg::CFG_INNER, 16'h7fff);
        write_reg(jrd_pkg::CFG_OUTER, 16'h7fff);
        send_sample(16'sd5000, -16'sd5000);
        send_sample(16'sd200, 16'sd10);
        drain();

        // Random phases with several settings and idle patterns.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin src_idle_pct = 18; snk_idle_pct = 62; end
                2: begin src_idle_pct = 62; snk_idle_pct = 18; end
                4: begin src_idle_pct = 0;  snk_idle_pct = 0;  end
                default: ;
            endcase
            if (ph == 5) begin
                write_reg(jrd_pkg::CFG_RAW_MIN, jrd_pkg::RST_RAW_MIN);
                write_reg(jrd_pkg::CFG_RAW_MAX, jrd_pkg::RST_RAW_MAX);
                write_reg(jrd_pkg::CFG_INNER, 16'(jrd_pkg::RST_INNER));
                write_reg(jrd_pkg::CFG_OUTER, 16'(jrd_pkg::RST_OUTER));
            end else begin
                write_reg(jrd_pkg::CFG_RAW_MIN, 16'($urandom_range(0, 65535)));
                write_reg(jrd_pkg::CFG_RAW_MAX, 16'($urandom_range(0, 65535)));
                if (ph % 2 == 0) begin
                    write_reg(jrd_pkg::CFG_RAW_MIN, 16'(-$urandom_range(1000, 32768)));
                    write_reg(jrd_pkg::CFG_RAW_MAX, 16'($urandom_range(1000, 32767)));
                end
                write_reg(jrd_pkg::CFG_INNER, 16'($urandom_range(0, 12000)));
                write_reg(jrd_pkg::CFG_OUTER, 16'($urandom_range(0, 12000)));
            end
            for (int k = 0; k < N_RANDOM / 6; k++) begin
                if ($urandom_range(3) == 0)
                    send_sample(16'($urandom), 16'($urandom));
                else
                    send_sample(16'($urandom_range(0, 65535) >> $urandom_range(0, 3)),
                                16'(-($urandom_range(0, 65535) >> $urandom_range(0, 3))));
            end
            drain();
        end

        $display("Covered %0d samples over directed extremes and six random phases,",
                 n_results);
        $display("including equal, inverted and full-scale raw ranges and zero deadzones.");
        if (n_errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

>>> filelist.f
hw/rtl/jrd_pkg.sv
hw/rtl/jrd_in_if.sv
hw/rtl/jrd_out_if.sv
hw/rtl/jrd_div.sv
hw/rtl/joystick_radial_deadzone.sv
verif/tb_top.sv
